[rtl/bba_pkg.sv]
// Package for the bitmap block allocator: state, status and opcode codes,
// bitmap word geometry and the find-first-free result type.
// No dependencies.
package bba_pkg;

    // Bitmap word geometry: one RAM word holds this many used bits
    localparam int WORD_W  = 32;
    localparam int WORD_AW = 5;

    // Opcodes of an input word
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes of a result word
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOMEM = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // Control states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DONE
    } state_t;

    // Lowest free bit of one bitmap word
    typedef struct packed {
        logic               found;
        logic [WORD_AW-1:0] pos;
    } ffs_res_t;

endpackage

[rtl/bba_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/bba_ffs.sv]
// Find-first-free: lowest set bit of a candidate mask over one bitmap word.
// Depends on bba_pkg.
module bba_ffs (
    input  logic [bba_pkg::WORD_W-1:0] free_bits,
    output bba_pkg::ffs_res_t          res
);

    // Priority encoder, lowest index wins
    always_comb
    begin
        res.found = |free_bits;
        res.pos   = '0;
        for (int b = bba_pkg::WORD_W - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                res.pos = bba_pkg::WORD_AW'(b);
            end
        end
    end

endmodule

[rtl/bitmap_block_allocator.sv]
// First-fit bitmap block allocator, top level.
// Depends on bba_pkg, bba_ram and bba_ffs.
//
// Usage:
//   Input channel (in_valid / in_stall): one word carries opcode and
//   block_index. Allocate grants the lowest free block below the active
//   count (min of total_blocks and NUM_BLOCKS); free clears one block.
//   Output channel (out_valid / out_stall): one result word per request,
//   allocated_block and status (ok, no free block, free index out of range).
//   Config channel (cfg_valid / cfg_ready): writes total_blocks; cfg_ready
//   is always high, writes belong in idle periods.
// Sequence:
//   RAM of 32-bit words with registered read data. A free reads its word
//   when accepted, then clears the bit if in range and goes to done; an
//   allocate reads words from word 0 up until one holds a free block or
//   the scan passes the active count. One request is in flight at a time;
//   in_stall is high until its result is loaded into the output register.
// Reset and stall:
//   After reset a clearing pass zeroes the RAM, one word per cycle, with
//   in_stall high. A stalled result holds in the output register; the next
//   request may be accepted meanwhile and its result waits in an internal
//   register until the output frees.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [9:0]  block_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  allocated_block,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] total_blocks
);

    localparam int WORDS = (NUM_BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int CW    = (CNT_W > 11) ? CNT_W : 11;
    localparam int XW    = CNT_W + 6;

    bba_pkg::state_t state_reg, state_next;
    logic [AW:0]     w_reg, w_next;
    logic [10:0]     total_blocks_reg;
    logic            op_reg;
    logic [9:0]      idx_reg;
    logic [9:0]      res_block_reg, res_block_next;
    logic [1:0]      res_status_reg, res_status_next;
    logic            out_valid_reg, out_valid_next;
    logic [9:0]      out_block_reg;
    logic [1:0]      out_status_reg;

    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [bba_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

    logic                       in_accept, out_load;
    logic [CW-1:0]              tb_wide, n_wide;
    logic [XW-1:0]              n_x, base_x, rem_x, idx_x, in_idx_x;
    logic [AW:0]                w_plus;
    logic [bba_pkg::WORD_W-1:0] range_mask, free_bits;
    bba_pkg::ffs_res_t          ffs;

    // Bitmap storage
    bba_ram #(
        .WIDTH(bba_pkg::WORD_W),
        .DEPTH(WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Lowest free block in the word under scan
    bba_ffs u_ffs (
        .free_bits (free_bits),
        .res       (ffs)
    );

    // Active count and scan geometry
    assign tb_wide  = CW'(total_blocks_reg);
    assign n_wide   = (tb_wide < CW'(NUM_BLOCKS)) ? tb_wide : CW'(NUM_BLOCKS);
    assign n_x      = XW'(n_wide);
    assign base_x   = XW'({w_reg, {bba_pkg::WORD_AW{1'b0}}});
    assign rem_x    = n_x - base_x;
    assign idx_x    = XW'(idx_reg);
    assign in_idx_x = XW'(block_index);
    assign w_plus   = w_reg + (AW + 1)'(1);

    // Blocks at or above the active count count as used
    always_comb
    begin
        if (rem_x >= XW'(bba_pkg::WORD_W))
        begin
            range_mask = '1;
        end
        else
        begin
            range_mask = (bba_pkg::WORD_W'(1) << rem_x[bba_pkg::WORD_AW-1:0])
                         - bba_pkg::WORD_W'(1);
        end
    end

    assign free_bits = ~ram_rdata & range_mask;

    // Handshakes
    assign in_stall  = (state_reg != bba_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == bba_pkg::S_DONE) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;

    // Next state, RAM access and result
    always_comb
    begin
        state_next      = state_reg;
        w_next          = w_reg;
        res_block_next  = res_block_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = w_reg[AW-1:0];
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                ram_we = 1'b1;
                w_next = w_plus;
                if (w_reg == (AW + 1)'(WORDS - 1))
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    ram_re = 1'b1;
                    w_next = '0;
                    if (opcode == bba_pkg::OP_FREE)
                    begin
                        ram_raddr = in_idx_x[AW+bba_pkg::WORD_AW-1:bba_pkg::WORD_AW];
                    end
                    state_next = bba_pkg::S_CHECK;
                end
            end
            bba_pkg::S_CHECK:
            begin
                res_block_next = '0;
                if (op_reg == bba_pkg::OP_FREE)
                begin
                    if (idx_x < n_x)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = idx_x[AW+bba_pkg::WORD_AW-1:bba_pkg::WORD_AW];
                        ram_wdata       = ram_rdata &
                                          ~(bba_pkg::WORD_W'(1) <<
                                            idx_reg[bba_pkg::WORD_AW-1:0]);
                        res_status_next = bba_pkg::STAT_OK;
                    end
                    else
                    begin
                        res_status_next = bba_pkg::STAT_RANGE;
                    end
                    state_next = bba_pkg::S_DONE;
                end
                else if (base_x >= n_x)
                begin
                    res_status_next = bba_pkg::STAT_NOMEM;
                    state_next      = bba_pkg::S_DONE;
                end
                else if (ffs.found)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = ram_rdata | (bba_pkg::WORD_W'(1) << ffs.pos);
                    res_block_next  = {base_x[9:bba_pkg::WORD_AW], ffs.pos};
                    res_status_next = bba_pkg::STAT_OK;
                    state_next      = bba_pkg::S_DONE;
                end
                else
                begin
                    // Word full: fetch the next one
                    ram_re    = 1'b1;
                    ram_raddr = w_plus[AW-1:0];
                    w_next    = w_plus;
                end
            end
            bba_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bba_pkg::S_CLEAR;
            w_reg            <= '0;
            out_valid_reg    <= 1'b0;
            total_blocks_reg <= 11'd1024;
        end
        else
        begin
            state_reg     <= state_next;
            w_reg         <= w_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                total_blocks_reg <= total_blocks;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= opcode;
            idx_reg <= block_index;
        end
        res_block_reg  <= res_block_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_block_reg  <= res_block_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign allocated_block = out_block_reg;
    assign status          = out_status_reg;

    // Failed requests never report a block number
    a_nomem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == bba_pkg::STAT_NOMEM || status == bba_pkg::STAT_RANGE))
        |-> (allocated_block == 10'd0))
        else $error("failed request reports nonzero block");

    // No request is taken during the clearing pass
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::S_CLEAR) |-> in_stall)
        else $error("request accepted during clearing pass");

    // Bitmap is written only by the clearing pass or the check step
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == bba_pkg::S_CLEAR || state_reg == bba_pkg::S_CHECK))
        else $error("bitmap write outside clear or check");

    // A held result does not change while the receiver stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(allocated_block)
                                      && $stable(status)))
        else $error("stalled result changed");

endmodule

[tb/tb_bitmap_block_allocator.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_block_allocator: directed and random
// allocate/free traffic against a bit-accurate bitmap predictor.
// Depends on bba_pkg and the bitmap_block_allocator RTL.
module tb_bitmap_block_allocator;

    localparam int          MAP_DEPTH   = 1024;
    localparam int unsigned CYCLE_LIMIT = 600000;

    // Expected result word of one request
    typedef struct packed {
        logic [9:0] block;
        logic [1:0] stat;
    } alloc_result_t;

    // Bitmap predictor and queue of expected result words
    class bitmap_tracker;
        bit            used [MAP_DEPTH];
        int unsigned   count_cfg;
        alloc_result_t pending_results [$];
        int            errors;

        function new();
            foreach (used[i])
            begin
                used[i] = 1'b0;
            end
            count_cfg = 1024;
            errors    = 0;
        endfunction

        function void set_count(logic [10:0] value);
            count_cfg = {21'd0, value};
        endfunction

        // Effective count is clipped to the bitmap depth
        function int unsigned active_count();
            return (count_cfg > MAP_DEPTH) ? MAP_DEPTH : count_cfg;
        endfunction

        // Apply one accepted request to the bitmap and queue its result
        function void note_request(logic op, logic [9:0] idx);
            int unsigned   n;
            alloc_result_t res;
            n         = active_count();
            res.block = '0;
            res.stat  = bba_pkg::STAT_OK;
            if (op == bba_pkg::OP_ALLOC)
            begin
                res.stat = bba_pkg::STAT_NOMEM;
                for (int i = 0; i < n; i++)
                begin
                    if (!used[i])
                    begin
                        used[i]   = 1'b1;
                        res.block = i[9:0];
                        res.stat  = bba_pkg::STAT_OK;
                        break;
                    end
                end
            end
            else if (idx < n)
            begin
                used[idx] = 1'b0;
            end
            else
            begin
                res.stat = bba_pkg::STAT_RANGE;
            end
            pending_results.push_back(res);
        endfunction

        // Compare one accepted result word with the oldest expectation
        function void check_result(logic [9:0] blk, logic [1:0] st);
            alloc_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: allocated_block %0d status %0d",
                       blk, st);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (blk !== exp_res.block)
            begin
                $error("allocated_block: expected %0d, actual %0d", exp_res.block, blk);
                errors++;
            end
            if (st !== exp_res.stat)
            begin
                $error("status: expected %0d, actual %0d", exp_res.stat, st);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // A used block below the limit if there is one, else any index
        function logic [9:0] pick_used(int unsigned lim);
            int unsigned start;
            int unsigned j;
            start = $urandom_range(MAP_DEPTH - 1, 0);
            for (int unsigned k = 0; k < MAP_DEPTH; k++)
            begin
                j = (start + k) % MAP_DEPTH;
                if (j < lim && used[j])
                begin
                    return j[9:0];
                end
            end
            return 10'($urandom_range(MAP_DEPTH - 1, 0));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [9:0]  block_index;
    logic        out_valid;
    logic        out_stall;
    logic [9:0]  allocated_block;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] total_blocks;

    bitmap_tracker sb;
    bit            quiet;            // no idle cycles on either side
    int            rx_hold  = 0;     // length of the next long receiver hold-off
    int            hold_req = 0;     // count of hold-offs asked for
    int unsigned   cycle_count = 0;

    bitmap_block_allocator #(
        .NUM_BLOCKS (MAP_DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .block_index     (block_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .allocated_block (allocated_block),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .total_blocks    (total_blocks)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bitmap_block_allocator: mismatch");
            $finish;
        end
    end

    // Offer one request word and hold it until accepted
    task automatic send_request(logic op, logic [9:0] idx);
        int gap;
        gap = quiet ? 0 : int'($urandom_range(10, 0));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        block_index <= idx;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_request(op, idx);
    endtask

    // Stop offering and wait until every expected result word is in
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write total_blocks while the block is idle
    task automatic set_block_count(logic [10:0] value);
        drain_results();
        cfg_valid    <= 1'b1;
        total_blocks <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_count(value);
    endtask

    // One random phase at a given block count
    task automatic run_phase(logic [10:0] count, int unsigned alloc_pct,
                             int unsigned n_items, int hold, bit calm,
                             bit pause_mid);
        int unsigned lim;
        int unsigned r;
        int          edge_idx;
        logic        op;
        logic [9:0]  idx;
        set_block_count(count);
        quiet = calm;
        if (hold > 0)
        begin
            rx_hold  = hold;
            hold_req = hold_req + 1;
        end
        lim = {21'd0, count};
        if (lim > MAP_DEPTH)
        begin
            lim = MAP_DEPTH;
        end
        for (int k = 0; k < n_items; k++)
        begin
            if (pause_mid && k == n_items / 2)
            begin
                drain_results();
            end
            op = ($urandom_range(99, 0) < alloc_pct) ? bba_pkg::OP_ALLOC : bba_pkg::OP_FREE;
            r  = $urandom_range(99, 0);
            if (op == bba_pkg::OP_ALLOC || r >= 80)
            begin
                idx = 10'($urandom_range(MAP_DEPTH - 1, 0));
            end
            else if (r < 55)
            begin
                idx = sb.pick_used(lim);
            end
            else
            begin
                // just below, at and just above the active count
                edge_idx = int'(lim) + int'($urandom_range(2, 0)) - 1;
                if (edge_idx < 0)
                begin
                    edge_idx = 0;
                end
                if (edge_idx > MAP_DEPTH - 1)
                begin
                    edge_idx = MAP_DEPTH - 1;
                end
                idx = edge_idx[9:0];
            end
            send_request(op, idx);
        end
        quiet = 1'b0;
    endtask

    // Result sink: random stall before each word, one long hold on request
    initial
    begin : result_sink
        int gap;
        int hold_taken;
        hold_taken = 0;
        out_stall  = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_taken != hold_req)
            begin
                gap        = rx_hold;
                hold_taken = hold_req;
            end
            else
            begin
                gap = quiet ? 0 : int'($urandom_range(10, 0));
            end
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_result(allocated_block, status);
        end
    end

    // Main sequence
    initial
    begin
        sb           = new();
        quiet        = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = bba_pkg::OP_ALLOC;
        block_index  = '0;
        cfg_valid    = 1'b0;
        total_blocks = 11'd1024;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset count, first fit, refree, empty and full maps
        send_request(bba_pkg::OP_ALLOC, 10'h3FF);
        send_request(bba_pkg::OP_ALLOC, 10'h000);
        send_request(bba_pkg::OP_ALLOC, 10'h155);
        send_request(bba_pkg::OP_FREE, 10'd1);
        send_request(bba_pkg::OP_ALLOC, 10'h2AA);
        send_request(bba_pkg::OP_FREE, 10'd1023);     // already free
        send_request(bba_pkg::OP_FREE, 10'd0);
        send_request(bba_pkg::OP_FREE, 10'd0);        // free twice
        send_request(bba_pkg::OP_ALLOC, 10'd0);
        set_block_count(11'd0);                       // nothing managed
        send_request(bba_pkg::OP_ALLOC, 10'd0);
        send_request(bba_pkg::OP_FREE, 10'd0);
        set_block_count(11'd2047);                    // clipped to bitmap depth
        send_request(bba_pkg::OP_FREE, 10'd1023);
        send_request(bba_pkg::OP_ALLOC, 10'd0);
        send_request(bba_pkg::OP_FREE, 10'h2AA);
        send_request(bba_pkg::OP_FREE, 10'h155);
        set_block_count(11'd3);                       // all blocks taken
        send_request(bba_pkg::OP_ALLOC, 10'd0);
        send_request(bba_pkg::OP_FREE, 10'd3);        // first index out of range
        send_request(bba_pkg::OP_FREE, 10'd2);
        send_request(bba_pkg::OP_ALLOC, 10'd0);
        send_request(bba_pkg::OP_ALLOC, 10'd0);
        set_block_count(11'd1);
        send_request(bba_pkg::OP_FREE, 10'd1023);
        send_request(bba_pkg::OP_FREE, 10'd0);
        send_request(bba_pkg::OP_ALLOC, 10'd0);

        // Random phases over a range of block counts
        run_phase(11'd1024, 70, 130, 0,   1'b0, 1'b0);
        run_phase(11'd5,    55, 130, 0,   1'b0, 1'b0);
        run_phase(11'd40,   60, 130, 160, 1'b0, 1'b0);
        run_phase(11'd0,    50, 40,  0,   1'b0, 1'b0);
        run_phase(11'd2047, 75, 130, 0,   1'b1, 1'b0);
        run_phase(11'd1,    50, 130, 0,   1'b0, 1'b0);
        run_phase(11'd64,   60, 130, 0,   1'b0, 1'b1);
        run_phase(11'd33,   65, 130, 0,   1'b0, 1'b0);
        run_phase(11'd1023, 60, 130, 0,   1'b1, 1'b0);
        run_phase(11'd200,  55, 130, 0,   1'b0, 1'b0);
        run_phase(11'd1024, 50, 130, 0,   1'b0, 1'b0);

        drain_results();
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("bitmap_block_allocator: match");
        end
        else
        begin
            $display("bitmap_block_allocator: mismatch");
        end
        $finish;
    end

endmodule
